// ----- rtl/gbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types, sizes and counter training for the gshare branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

    // Table depth must be a power of two: the hash keeps the low index bits.
    localparam int TABLE_ENTRIES = 4096;
    localparam int HISTORY_BITS  = 12;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CTR_W         = 2;

    localparam int ACTION_W = 3;
    localparam int PC_W     = 32;
    localparam int SNAP_W   = 12;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP   = 3'd0,
        ACT_UNCOND   = 3'd1,
        ACT_BTB_MISS = 3'd2,
        ACT_RESOLVE  = 3'd3,
        ACT_SQUASH   = 3'd4
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [PC_W-1:0]     pc;
        logic                taken;
        logic                mispredicted;
        logic [SNAP_W-1:0]   saved_history;
        logic [SNAP_W-1:0]   saved_index;
        logic [CTR_W-1:0]    saved_counter;
    } t_req;

    // Two-bit counter update; strong taken falls to weak taken only from the
    // top state, the middle states jump to the ends.
    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] ctr,
                                                input logic t);
        logic [CTR_W-1:0] n;
        begin
            case (ctr)
                2'd3:    n = t ? 2'd3 : 2'd2;
                2'd2:    n = t ? 2'd3 : 2'd0;
                2'd1:    n = t ? 2'd3 : 2'd0;
                default: n = t ? 2'd1 : 2'd0;
            endcase
            return n;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/gbp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_ram
// Generic single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/gbp_history.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_history
// Global history register and the table index hash for each transaction.
// ----------------------------------------------------------------------------
module gbp_history (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_accept,
    input  wire gbp_pkg::t_req                      i_req,
    output logic      [gbp_pkg::HISTORY_BITS-1:0]   o_history,
    output logic      [gbp_pkg::IDX_W-1:0]          o_index
);
    import gbp_pkg::*;

    logic [HISTORY_BITS-1:0] r_history;
    logic [HISTORY_BITS-1:0] n_history;
    logic [HISTORY_BITS-1:0] w_saved;
    logic [HISTORY_BITS-1:0] w_shift_base;
    logic [HISTORY_BITS-1:0] w_shifted_nt;
    logic [PC_W-1:0]         w_hash_cur;
    logic [PC_W-1:0]         w_hash_nt;

    assign w_saved      = HISTORY_BITS'(i_req.saved_history);
    assign w_shifted_nt = r_history >> 1;
    assign w_hash_cur   = PC_W'(r_history) ^ i_req.pc;
    assign w_hash_nt    = PC_W'(w_shifted_nt) ^ i_req.pc;

    // Resolve on a misprediction restores first, then shifts.
    assign w_shift_base = i_req.mispredicted ? w_saved : r_history;

    always_comb begin
        n_history = r_history;
        o_index   = w_hash_cur[IDX_W-1:0];
        case (i_req.action)
            ACT_LOOKUP: begin
            end
            ACT_UNCOND: begin
                n_history                 = r_history >> 1;
                n_history[HISTORY_BITS-1] = 1'b1;
            end
            ACT_BTB_MISS: begin
                n_history = w_shifted_nt;
                o_index   = w_hash_nt[IDX_W-1:0];
            end
            ACT_RESOLVE: begin
                n_history                 = w_shift_base >> 1;
                n_history[HISTORY_BITS-1] = i_req.taken;
                if (i_req.mispredicted) begin
                    o_index = IDX_W'(i_req.saved_index);
                end
            end
            ACT_SQUASH: begin
                n_history = w_saved;
                o_index   = IDX_W'(i_req.saved_index);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history <= '0;
        end else if (i_accept) begin
            r_history <= n_history;
        end
    end

    assign o_history = r_history;

endmodule
`default_nettype wire

// ----- rtl/gshare_branch_predictor_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gshare_branch_predictor_top
// gshare predictor: global history, 2-bit counter table in one RAM.
// ----------------------------------------------------------------------------
// Each transaction is handled in order: the accepting edge updates the history
// and issues the counter RAM read, the next cycle reads the counter back and
// writes any trained or restored value through the same single RAM port. busy is high for
// that one cycle, and o_valid marks the result for one cycle after it, while a
// new transaction may already be accepted; results cannot be held off. After
// reset busy stays high for a clearing pass over all 4096 counter RAM entries.
module gshare_branch_predictor_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [gbp_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [gbp_pkg::PC_W-1:0]       i_pc,
    input  wire logic                           i_taken,
    input  wire logic                           i_mispredicted,
    input  wire logic [gbp_pkg::SNAP_W-1:0]     i_saved_history,
    input  wire logic [gbp_pkg::SNAP_W-1:0]     i_saved_index,
    input  wire logic [gbp_pkg::CTR_W-1:0]      i_saved_counter,
    output logic                                o_valid,
    output logic                                o_predict_taken,
    output logic      [gbp_pkg::SNAP_W-1:0]     o_history_snapshot,
    output logic      [gbp_pkg::SNAP_W-1:0]     o_index_snapshot,
    output logic      [gbp_pkg::CTR_W-1:0]      o_counter_snapshot
);
    import gbp_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    logic [IDX_W-1:0]        r_clr_cnt;
    t_req                    r_req;
    logic [IDX_W-1:0]        r_index;
    logic [HISTORY_BITS-1:0] r_hist_snap;

    t_req                    w_req;
    logic                    w_accept;
    logic [HISTORY_BITS-1:0] w_history;
    logic [IDX_W-1:0]        w_index;
    logic [CTR_W-1:0]        w_rdata;
    logic                    w_we;
    logic [IDX_W-1:0]        w_addr;
    logic [CTR_W-1:0]        w_wdata;
    logic                    w_exec_we;
    logic [CTR_W-1:0]        w_exec_wdata;

    assign w_req = '{
        action:        t_action'(i_action),
        pc:            i_pc,
        taken:         i_taken,
        mispredicted:  i_mispredicted,
        saved_history: i_saved_history,
        saved_index:   i_saved_index,
        saved_counter: i_saved_counter
    };

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    gbp_history u_history (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_req     (w_req),
        .o_history (w_history),
        .o_index   (w_index)
    );

    // Write-back of the trained counter, or on a squash the restored one, in the cycle after the read.
    always_comb begin
        w_exec_we    = 1'b0;
        w_exec_wdata = w_rdata;
        case (r_req.action)
            ACT_BTB_MISS: begin
                w_exec_we    = 1'b1;
                w_exec_wdata = train(w_rdata, 1'b0);
            end
            ACT_RESOLVE: begin
                w_exec_we    = 1'b1;
                w_exec_wdata = train(r_req.mispredicted ? r_req.saved_counter : w_rdata,
                                     r_req.taken);
            end
            ACT_SQUASH: begin
                w_exec_we    = 1'b1;
                w_exec_wdata = r_req.saved_counter;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_addr  = r_clr_cnt;
                w_wdata = '0;
            end
            S_EXEC: begin
                w_we    = w_exec_we;
                w_addr  = r_index;
                w_wdata = w_exec_wdata;
            end
            default: begin
                w_we    = 1'b0;
                w_addr  = w_index;
                w_wdata = '0;
            end
        endcase
    end

    gbp_ram #(
        .WIDTH (CTR_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_counter_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            o_valid   <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    o_valid   <= 1'b0;
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (start) begin
                        r_req       <= w_req;
                        r_index     <= w_index;
                        r_hist_snap <= w_history;
                        r_state     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    o_valid            <= 1'b1;
                    o_predict_taken    <= 1'b0;
                    o_history_snapshot <= '0;
                    o_index_snapshot   <= '0;
                    o_counter_snapshot <= '0;
                    if (r_req.action == ACT_LOOKUP || r_req.action == ACT_UNCOND) begin
                        o_predict_taken    <= (r_req.action == ACT_UNCOND) || w_rdata[1];
                        o_history_snapshot <= SNAP_W'(r_hist_snap);
                        o_index_snapshot   <= SNAP_W'(r_index);
                        o_counter_snapshot <= w_rdata;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/gbp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_checker
// Port-level checks on the predictor's transaction timing and result fields.
// ----------------------------------------------------------------------------
module gbp_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         o_valid,
    input  wire logic                         o_predict_taken,
    input  wire logic [gbp_pkg::CTR_W-1:0]    o_counter_snapshot
);
    import gbp_pkg::*;

    // An accepted transaction yields its result once its execute state has passed.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result missing two cycles after accept");

    // No result without a transaction in flight the cycle before.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a transaction in flight");

    // Results never come in consecutive cycles.
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // A high counter snapshot always predicts taken.
    a_predict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_counter_snapshot[1]) |-> o_predict_taken)
        else $error("prediction disagrees with counter snapshot");

endmodule

bind gshare_branch_predictor_top gbp_checker u_gbp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_predict_taken    (o_predict_taken),
    .o_counter_snapshot (o_counter_snapshot)
);
`default_nettype wire
